FILE: rtl/c_subset_token_lexer_assert.svh
// ---------------------------------------------------------------------------
// c_subset_token_lexer_assert.svh
// assertion macros shared by the lexer rtl
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_TOKEN_LEXER_ASSERT_SVH
`define C_SUBSET_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ctl_pkg.sv
// ---------------------------------------------------------------------------
// ctl_pkg
// widths, token codes, token record and character classes of the lexer
// ---------------------------------------------------------------------------
package ctl_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 8;
    localparam int POS_W  = 16;

    localparam logic [KIND_W-1:0] KIND_INT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RETURN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd6;

    localparam logic [1:0] CAND_NONE   = 2'd0;
    localparam logic [1:0] CAND_INT    = 2'd1;
    localparam logic [1:0] CAND_RETURN = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] sym;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  col;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_token;

    // up to two tokens produced by one byte, tok0 first
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token tok0;
        t_token tok1;
    } t_tok_pair;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_symbol(input logic [CHAR_W-1:0] c);
        return c == "*" || c == "+" || c == "-" || c == "=" || c == ";" ||
               c == "," || c == "(" || c == ")" || c == "{" || c == "}";
    endfunction

    // next keyword letter matches the candidate word at this position
    function automatic logic kw_match(input logic [1:0] cand, input logic [2:0] prog,
                                      input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] want;
        logic              ok;
        want = 8'h00;
        ok   = 1'b0;
        if (cand == CAND_INT) begin
            ok = prog < 3'd3;
            case (prog)
                3'd0:    want = "i";
                3'd1:    want = "n";
                3'd2:    want = "t";
                default: want = 8'h00;
            endcase
        end else if (cand == CAND_RETURN) begin
            ok = prog < 3'd6;
            case (prog)
                3'd0:    want = "r";
                3'd1:    want = "e";
                3'd2:    want = "t";
                3'd3:    want = "u";
                3'd4:    want = "r";
                3'd5:    want = "n";
                default: want = 8'h00;
            endcase
        end
        return ok && (want == c);
    endfunction

endpackage

FILE: rtl/ctl_if.sv
// ---------------------------------------------------------------------------
// ctl_if
// valid/ready channels for source bytes and for tokens
// ---------------------------------------------------------------------------
interface ctl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface ctl_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  symbol_code;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [7:0]  token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output symbol_code, output token_line,
                    output token_column, output token_length, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input symbol_code, input token_line,
                    input token_column, input token_length, input last_of_run,
                    output ready);
endinterface

FILE: rtl/ctl_lex_core.sv
// ---------------------------------------------------------------------------
// ctl_lex_core
// lexer state and one-byte step, producing up to two tokens per byte
// ---------------------------------------------------------------------------
`include "c_subset_token_lexer_assert.svh"

module ctl_lex_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ctl_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_eoi,
    output ctl_pkg::t_tok_pair         o_push
);

    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_IDENT      = 3'd1;
    localparam logic [2:0] MODE_NUMBER     = 3'd2;
    localparam logic [2:0] MODE_SLASH      = 3'd3;
    localparam logic [2:0] MODE_LINE_CMT   = 3'd4;
    localparam logic [2:0] MODE_BLOCK      = 3'd5;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd6;
    localparam logic [2:0] MODE_HALTED     = 3'd7;

    localparam logic [ctl_pkg::LEN_W-1:0] LEN_MAX = {ctl_pkg::LEN_W{1'b1}};
    localparam logic [ctl_pkg::POS_W-1:0] POS_MAX = {ctl_pkg::POS_W{1'b1}};

    logic [2:0]                r_mode, n_mode;
    logic [2:0]                r_prog, n_prog;
    logic [1:0]                r_cand, n_cand;
    logic [ctl_pkg::LEN_W-1:0] r_pend_len, n_pend_len;
    logic [ctl_pkg::POS_W-1:0] r_pend_line, n_pend_line;
    logic [ctl_pkg::POS_W-1:0] r_pend_col, n_pend_col;
    logic [ctl_pkg::POS_W-1:0] r_line, n_line;
    logic [ctl_pkg::POS_W-1:0] r_col, n_col;

    logic            do_flush;
    logic            do_idle;
    logic            flush_v;
    logic            idle_v;
    logic            end_v;
    logic            a_v;
    logic            b_v;
    ctl_pkg::t_token flush_tok;
    ctl_pkg::t_token idle_tok;
    ctl_pkg::t_token b_tok;

    // token held by the pending identifier, number or slash
    always_comb begin
        flush_tok      = '0;
        flush_tok.line = r_pend_line;
        flush_tok.col  = r_pend_col;
        flush_tok.len  = r_pend_len;
        flush_v        = 1'b0;
        case (r_mode)
            MODE_IDENT: begin
                flush_v = 1'b1;
                if (r_cand == ctl_pkg::CAND_INT && r_prog == 3'd3) begin
                    flush_tok.kind = ctl_pkg::KIND_INT;
                end else if (r_cand == ctl_pkg::CAND_RETURN && r_prog == 3'd6) begin
                    flush_tok.kind = ctl_pkg::KIND_RETURN;
                end else begin
                    flush_tok.kind = ctl_pkg::KIND_IDENT;
                end
            end
            MODE_NUMBER: begin
                flush_v        = 1'b1;
                flush_tok.kind = ctl_pkg::KIND_NUMBER;
            end
            MODE_SLASH: begin
                flush_v        = 1'b1;
                flush_tok.kind = ctl_pkg::KIND_SYMBOL;
                flush_tok.sym  = ctl_pkg::CH_SLASH;
                flush_tok.len  = ctl_pkg::LEN_W'(1);
            end
            default: begin
                flush_v = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_prog      = r_prog;
        n_cand      = r_cand;
        n_pend_len  = r_pend_len;
        n_pend_line = r_pend_line;
        n_pend_col  = r_pend_col;
        n_line      = r_line;
        n_col       = r_col;
        do_flush    = 1'b0;
        do_idle     = 1'b0;
        end_v       = 1'b0;
        idle_v      = 1'b0;
        idle_tok    = '0;

        if (i_step && r_mode != MODE_HALTED) begin
            if (i_eoi) begin
                do_flush = 1'b1;
                end_v    = 1'b1;
            end else begin
                unique case (r_mode)
                    MODE_IDENT: begin
                        if (ctl_pkg::is_letter(i_char) || ctl_pkg::is_digit(i_char)) begin
                            if (r_pend_len != LEN_MAX) begin
                                n_pend_len = r_pend_len + 1'b1;
                            end
                            if (ctl_pkg::kw_match(r_cand, r_prog, i_char)) begin
                                n_prog = r_prog + 1'b1;
                            end else begin
                                n_cand = ctl_pkg::CAND_NONE;
                                n_prog = 3'd0;
                            end
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (ctl_pkg::is_digit(i_char)) begin
                            if (r_pend_len != LEN_MAX) begin
                                n_pend_len = r_pend_len + 1'b1;
                            end
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    MODE_SLASH: begin
                        if (i_char == ctl_pkg::CH_SLASH) begin
                            n_mode     = MODE_LINE_CMT;
                            n_pend_len = '0;
                        end else if (i_char == ctl_pkg::CH_STAR) begin
                            n_mode     = MODE_BLOCK;
                            n_pend_len = '0;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    MODE_LINE_CMT: begin
                        if (i_char == ctl_pkg::CH_NEWLINE) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_BLOCK: begin
                        if (i_char == ctl_pkg::CH_STAR) begin
                            n_mode = MODE_BLOCK_STAR;
                        end
                    end
                    MODE_BLOCK_STAR: begin
                        if (i_char == ctl_pkg::CH_SLASH) begin
                            n_mode = MODE_IDLE;
                        end else if (i_char != ctl_pkg::CH_STAR) begin
                            n_mode = MODE_BLOCK;
                        end
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase

                if (i_char == ctl_pkg::CH_NEWLINE) begin
                    if (r_line != POS_MAX) begin
                        n_line = r_line + 1'b1;
                    end
                    n_col = '0;
                end else if (r_col != POS_MAX) begin
                    n_col = r_col + 1'b1;
                end
            end
        end

        if (do_flush) begin
            n_mode     = MODE_IDLE;
            n_cand     = ctl_pkg::CAND_NONE;
            n_prog     = 3'd0;
            n_pend_len = '0;
        end

        // byte lexed from idle, possibly right after a flush
        if (do_idle) begin
            idle_tok.line = r_line;
            idle_tok.col  = r_col;
            idle_tok.len  = ctl_pkg::LEN_W'(1);
            if (ctl_pkg::is_space(i_char)) begin
                idle_v = 1'b0;
            end else if (ctl_pkg::is_letter(i_char)) begin
                n_mode      = MODE_IDENT;
                n_pend_line = r_line;
                n_pend_col  = r_col;
                n_pend_len  = ctl_pkg::LEN_W'(1);
                if (i_char == "i") begin
                    n_cand = ctl_pkg::CAND_INT;
                    n_prog = 3'd1;
                end else if (i_char == "r") begin
                    n_cand = ctl_pkg::CAND_RETURN;
                    n_prog = 3'd1;
                end else begin
                    n_cand = ctl_pkg::CAND_NONE;
                    n_prog = 3'd0;
                end
            end else if (i_char == ctl_pkg::CH_ZERO) begin
                idle_v        = 1'b1;
                idle_tok.kind = ctl_pkg::KIND_NUMBER;
            end else if (ctl_pkg::is_digit(i_char)) begin
                n_mode      = MODE_NUMBER;
                n_pend_line = r_line;
                n_pend_col  = r_col;
                n_pend_len  = ctl_pkg::LEN_W'(1);
            end else if (i_char == ctl_pkg::CH_SLASH) begin
                n_mode      = MODE_SLASH;
                n_pend_line = r_line;
                n_pend_col  = r_col;
                n_pend_len  = ctl_pkg::LEN_W'(1);
            end else if (ctl_pkg::is_symbol(i_char)) begin
                idle_v        = 1'b1;
                idle_tok.kind = ctl_pkg::KIND_SYMBOL;
                idle_tok.sym  = i_char;
            end else begin
                idle_v        = 1'b1;
                idle_tok.kind = ctl_pkg::KIND_ERROR;
                idle_tok.sym  = i_char;
                n_mode        = MODE_HALTED;
            end
        end

        // end of input clears everything, position included
        if (end_v) begin
            idle_tok      = '0;
            idle_tok.kind = ctl_pkg::KIND_END;
            idle_tok.line = r_line;
            idle_tok.col  = r_col;
            n_mode        = MODE_IDLE;
            n_cand        = ctl_pkg::CAND_NONE;
            n_prog        = 3'd0;
            n_pend_len    = '0;
            n_pend_line   = '0;
            n_pend_col    = '0;
            n_line        = '0;
            n_col         = '0;
        end
    end

    assign a_v = do_flush && flush_v;
    assign b_v = idle_v || end_v;

    always_comb begin
        b_tok            = idle_tok;
        b_tok.last       = 1'b1;
        o_push.v0        = a_v || b_v;
        o_push.v1        = a_v && b_v;
        o_push.tok0      = a_v ? flush_tok : b_tok;
        o_push.tok0.last = !(a_v && b_v);
        o_push.tok1      = b_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_prog      <= 3'd0;
            r_cand      <= ctl_pkg::CAND_NONE;
            r_pend_len  <= '0;
            r_pend_line <= '0;
            r_pend_col  <= '0;
            r_line      <= '0;
            r_col       <= '0;
        end else begin
            r_mode      <= n_mode;
            r_prog      <= n_prog;
            r_cand      <= n_cand;
            r_pend_len  <= n_pend_len;
            r_pend_line <= n_pend_line;
            r_pend_col  <= n_pend_col;
            r_line      <= n_line;
            r_col       <= n_col;
        end
    end

    `CTL_ASSERT_NEXT(a_halt_sticks, i_clk, i_rst_n, r_mode == MODE_HALTED, r_mode == MODE_HALTED, "halted lexer left halt without reset")
    `CTL_ASSERT_NEXT(a_eoi_rewinds, i_clk, i_rst_n, i_step && i_eoi && r_mode != MODE_HALTED, r_line == '0 && r_col == '0 && r_mode == MODE_IDLE, "end of input did not rewind position")
    `CTL_ASSERT_SAME(a_no_step_no_tok, i_clk, i_rst_n, !i_step, !o_push.v0 && !o_push.v1, "token produced without a step")

endmodule

FILE: rtl/ctl_tok_fifo.sv
// ---------------------------------------------------------------------------
// ctl_tok_fifo
// small token queue taking up to two tokens per cycle, draining one while the reader is ready
// ---------------------------------------------------------------------------
`include "c_subset_token_lexer_assert.svh"

module ctl_tok_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctl_pkg::t_tok_pair i_push,
    input  logic               i_pop_ready,
    output logic               o_room2,
    output logic               o_valid,
    output ctl_pkg::t_token    o_head
);

    ctl_pkg::t_token                 r_mem [ctl_pkg::FIFO_DEPTH];
    logic [ctl_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [ctl_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [ctl_pkg::FIFO_CNT_W-1:0]  r_cnt;
    logic [ctl_pkg::FIFO_CNT_W-1:0]  n_cnt;
    logic [ctl_pkg::FIFO_PTR_W-1:0]  wr_ptr1;
    logic [ctl_pkg::FIFO_CNT_W-1:0]  push_n;
    logic                            pop;

    assign push_n  = ctl_pkg::FIFO_CNT_W'(i_push.v0) + ctl_pkg::FIFO_CNT_W'(i_push.v1);
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign pop     = (r_cnt != '0) && i_pop_ready;
    assign n_cnt   = r_cnt + push_n - ctl_pkg::FIFO_CNT_W'(pop);

    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room2 = r_cnt <= ctl_pkg::FIFO_CNT_W'(ctl_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr1] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ctl_pkg::FIFO_PTR_W'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    `CTL_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= ctl_pkg::FIFO_CNT_W'(ctl_pkg::FIFO_DEPTH), "token queue count out of range")
    `CTL_ASSERT_SAME(a_push_room, i_clk, i_rst_n, i_push.v0, o_room2, "tokens pushed without room for two")
    `CTL_ASSERT_NEXT(a_head_held, i_clk, i_rst_n, o_valid && !i_pop_ready, o_valid && $stable(o_head), "token head changed while stalled")

endmodule

FILE: rtl/c_subset_token_lexer.sv
// ---------------------------------------------------------------------------
// c_subset_token_lexer
// streaming lexer for a small C subset, one source byte per transfer
// ---------------------------------------------------------------------------
// Usage:
//   i_byte  carries one source byte per transfer, or an end-of-input mark
//           (end_of_input high, char_code ignored).
//   o_token carries tokens: kind, symbol byte, start line and column,
//           length and a flag on the last token caused by one input byte.
//   A byte is taken into an input register, stepped through the lexer once
//   the queue has room for two tokens, and its tokens land in a four-entry
//   token queue, from whose head they are offered to the receiver.
//   Throughput is one byte per cycle while the queue has room; a byte that
//   ends a pending token and starts a symbol yields two tokens, which drain
//   one per cycle from the queue while the receiver is ready. The lexer steps
//   only while the queue has room for two tokens. When the receiver stalls
//   the queue fills and i_byte.ready drops; no token is lost or repeated.
//   Reset returns the lexer to idle at line 0, column 0 and empties the
//   queue. After an error token the lexer ignores all input until reset.
//   End of input flushes the pending token, sends the end token and
//   rewinds the position for a new stream.
// ---------------------------------------------------------------------------
module c_subset_token_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctl_byte_if.sink    i_byte,
    ctl_token_if.source o_token
);

    logic                       r_in_valid;
    logic [ctl_pkg::CHAR_W-1:0] r_char;
    logic                       r_eoi;
    logic                       room2;
    logic                       step;
    ctl_pkg::t_tok_pair         push;
    ctl_pkg::t_token            head;

    assign step         = r_in_valid && room2;
    assign i_byte.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_char <= i_byte.char_code;
            r_eoi  <= i_byte.end_of_input;
        end
    end

    ctl_lex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_eoi   (r_eoi),
        .o_push  (push)
    );

    ctl_tok_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (o_token.ready),
        .o_room2     (room2),
        .o_valid     (o_token.valid),
        .o_head      (head)
    );

    assign o_token.token_kind   = head.kind;
    assign o_token.symbol_code  = head.sym;
    assign o_token.token_line   = head.line;
    assign o_token.token_column = head.col;
    assign o_token.token_length = head.len;
    assign o_token.last_of_run  = head.last;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// streams source bytes into the lexer and checks every token it sends back
// against a token predictor kept in step with the accepted bytes; covers
// keywords, comments, two-token bytes, saturation of length, and the halt
// after an illegal byte
// ---------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_BYTES = 400;
    localparam int INT_CHARS = 3;
    localparam int RETURN_CHARS = 6;
    localparam logic [8*INT_CHARS-1:0]    WORD_INT    = "int";
    localparam logic [8*RETURN_CHARS-1:0] WORD_RETURN = "return";
    localparam logic [ctl_pkg::LEN_W-1:0] LEN_TOP = '1;
    localparam logic [ctl_pkg::POS_W-1:0] POS_TOP = '1;

    localparam logic [2:0] LX_IDLE       = 3'd0;
    localparam logic [2:0] LX_IDENT      = 3'd1;
    localparam logic [2:0] LX_NUMBER     = 3'd2;
    localparam logic [2:0] LX_SLASH      = 3'd3;
    localparam logic [2:0] LX_LINE_CMT   = 3'd4;
    localparam logic [2:0] LX_BLOCK      = 3'd5;
    localparam logic [2:0] LX_BLOCK_STAR = 3'd6;
    localparam logic [2:0] LX_HALTED     = 3'd7;

    typedef struct packed {
        logic [ctl_pkg::CHAR_W-1:0] ch;
        logic                       eoi;
    } t_src_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // source side
    logic                       src_valid = 1'b0;
    logic [ctl_pkg::CHAR_W-1:0] src_char = '0;
    logic                       src_eoi = 1'b0;
    logic                       snk_ready = 1'b0;
    int                         src_idle_pct = 0;
    int                         snk_idle_pct = 0;
    t_src_item                  byte_queue[$];
    t_src_item                  next_item;
    int                         gen_count = 0;

    // predictor state
    logic [2:0]                 lx_mode = LX_IDLE;
    logic [2:0]                 kw_pos = '0;
    logic [1:0]                 kw_cand = ctl_pkg::CAND_NONE;
    logic [ctl_pkg::LEN_W-1:0]  word_len = '0;
    logic [ctl_pkg::POS_W-1:0]  word_line = '0;
    logic [ctl_pkg::POS_W-1:0]  word_col = '0;
    logic [ctl_pkg::POS_W-1:0]  at_line = '0;
    logic [ctl_pkg::POS_W-1:0]  at_col = '0;
    ctl_pkg::t_token            step_tokens[$];
    ctl_pkg::t_token            tokens_due[$];

    // checking
    ctl_pkg::t_token got_tok;
    ctl_pkg::t_token want_tok;
    int              mismatches = 0;
    int              tokens_seen = 0;
    int              bytes_in = 0;
    int              ends_in = 0;
    int              idle_cycles = 0;

    ctl_byte_if  byte_ch();
    ctl_token_if tok_ch();

    assign byte_ch.valid        = src_valid;
    assign byte_ch.char_code    = src_char;
    assign byte_ch.end_of_input = src_eoi;
    assign tok_ch.ready         = snk_ready;

    c_subset_token_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_token (tok_ch)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- character classes ----------------

    function automatic logic char_alpha(input logic [ctl_pkg::CHAR_W-1:0] c);
        logic [ctl_pkg::CHAR_W-1:0] up;
        up = c & 8'hDF;
        return up >= "A" && up <= "Z";
    endfunction

    function automatic logic char_numeral(input logic [ctl_pkg::CHAR_W-1:0] c);
        return c[7:4] == 4'h3 && c[3:0] <= 4'd9;
    endfunction

    function automatic logic char_blank(input logic [ctl_pkg::CHAR_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic char_punct(input logic [ctl_pkg::CHAR_W-1:0] c);
        case (c)
            "*", "+", "-", "=", ";", ",", "(", ")", "{", "}": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // letter the candidate keyword needs at this position, 0 once past its end
    function automatic logic [ctl_pkg::CHAR_W-1:0] kw_letter(input logic [1:0] cand,
                                                            input logic [2:0] pos);
        int p;
        p = int'(pos);
        if (cand == ctl_pkg::CAND_INT && p < INT_CHARS)
            return WORD_INT[8*(INT_CHARS-1-p) +: 8];
        if (cand == ctl_pkg::CAND_RETURN && p < RETURN_CHARS)
            return WORD_RETURN[8*(RETURN_CHARS-1-p) +: 8];
        return 8'h00;
    endfunction

    // ---------------- token predictor ----------------

    function automatic void add_token(input logic [ctl_pkg::KIND_W-1:0] kind,
                                      input logic [ctl_pkg::CHAR_W-1:0] sym,
                                      input logic [ctl_pkg::POS_W-1:0] ln,
                                      input logic [ctl_pkg::POS_W-1:0] cl,
                                      input logic [ctl_pkg::LEN_W-1:0] len);
        ctl_pkg::t_token t;
        t = '{kind, sym, ln, cl, len, 1'b0};
        step_tokens.push_back(t);
    endfunction

    function automatic void lexer_reset();
        lx_mode   = LX_IDLE;
        kw_pos    = '0;
        kw_cand   = ctl_pkg::CAND_NONE;
        word_len  = '0;
        word_line = '0;
        word_col  = '0;
        at_line   = '0;
        at_col    = '0;
    endfunction

    function automatic void close_word();
        logic [ctl_pkg::KIND_W-1:0] kind;
        if (lx_mode == LX_IDENT) begin
            kind = ctl_pkg::KIND_IDENT;
            if (kw_cand == ctl_pkg::CAND_INT && kw_pos == INT_CHARS)
                kind = ctl_pkg::KIND_INT;
            else if (kw_cand == ctl_pkg::CAND_RETURN && kw_pos == RETURN_CHARS)
                kind = ctl_pkg::KIND_RETURN;
            add_token(kind, 8'h00, word_line, word_col, word_len);
        end else if (lx_mode == LX_NUMBER) begin
            add_token(ctl_pkg::KIND_NUMBER, 8'h00, word_line, word_col, word_len);
        end else if (lx_mode == LX_SLASH) begin
            add_token(ctl_pkg::KIND_SYMBOL, ctl_pkg::CH_SLASH, word_line, word_col,
                      ctl_pkg::LEN_W'(1));
        end
        lx_mode  = LX_IDLE;
        kw_cand  = ctl_pkg::CAND_NONE;
        kw_pos   = '0;
        word_len = '0;
    endfunction

    function automatic void open_word(input logic [2:0] m);
        lx_mode   = m;
        word_line = at_line;
        word_col  = at_col;
        word_len  = ctl_pkg::LEN_W'(1);
    endfunction

    // byte seen with nothing pending
    function automatic void lex_fresh(input logic [ctl_pkg::CHAR_W-1:0] c);
        if (char_blank(c)) begin
        end else if (char_alpha(c)) begin
            open_word(LX_IDENT);
            kw_cand = (c == "i") ? ctl_pkg::CAND_INT :
                      (c == "r") ? ctl_pkg::CAND_RETURN : ctl_pkg::CAND_NONE;
            kw_pos  = (kw_cand != ctl_pkg::CAND_NONE) ? 3'd1 : 3'd0;
        end else if (c == ctl_pkg::CH_ZERO) begin
            add_token(ctl_pkg::KIND_NUMBER, 8'h00, at_line, at_col, ctl_pkg::LEN_W'(1));
        end else if (char_numeral(c)) begin
            open_word(LX_NUMBER);
        end else if (c == ctl_pkg::CH_SLASH) begin
            open_word(LX_SLASH);
        end else if (char_punct(c)) begin
            add_token(ctl_pkg::KIND_SYMBOL, c, at_line, at_col, ctl_pkg::LEN_W'(1));
        end else begin
            add_token(ctl_pkg::KIND_ERROR, c, at_line, at_col, ctl_pkg::LEN_W'(1));
            lx_mode = LX_HALTED;
        end
    endfunction

    function automatic void lex_byte(input logic [ctl_pkg::CHAR_W-1:0] c, input logic eoi);
        ctl_pkg::t_token t;
        step_tokens.delete();
        if (lx_mode == LX_HALTED) begin
        end else if (eoi) begin
            close_word();
            add_token(ctl_pkg::KIND_END, 8'h00, at_line, at_col, '0);
            lexer_reset();
        end else begin
            case (lx_mode)
                LX_IDENT: begin
                    if (char_alpha(c) || char_numeral(c)) begin
                        if (word_len != LEN_TOP)
                            word_len = word_len + 1'b1;
                        if (kw_cand != ctl_pkg::CAND_NONE &&
                            kw_letter(kw_cand, kw_pos) == c) begin
                            kw_pos = kw_pos + 1'b1;
                        end else begin
                            kw_cand = ctl_pkg::CAND_NONE;
                            kw_pos  = '0;
                        end
                    end else begin
                        close_word();
                        lex_fresh(c);
                    end
                end
                LX_NUMBER: begin
                    if (char_numeral(c)) begin
                        if (word_len != LEN_TOP)
                            word_len = word_len + 1'b1;
                    end else begin
                        close_word();
                        lex_fresh(c);
                    end
                end
                LX_SLASH: begin
                    if (c == ctl_pkg::CH_SLASH) begin
                        lx_mode  = LX_LINE_CMT;
                        word_len = '0;
                    end else if (c == ctl_pkg::CH_STAR) begin
                        lx_mode  = LX_BLOCK;
                        word_len = '0;
                    end else begin
                        close_word();
                        lex_fresh(c);
                    end
                end
                LX_LINE_CMT: begin
                    if (c == ctl_pkg::CH_NEWLINE)
                        lx_mode = LX_IDLE;
                end
                LX_BLOCK: begin
                    if (c == ctl_pkg::CH_STAR)
                        lx_mode = LX_BLOCK_STAR;
                end
                LX_BLOCK_STAR: begin
                    if (c == ctl_pkg::CH_SLASH)
                        lx_mode = LX_IDLE;
                    else if (c != ctl_pkg::CH_STAR)
                        lx_mode = LX_BLOCK;
                end
                default: lex_fresh(c);
            endcase
            if (c == ctl_pkg::CH_NEWLINE) begin
                if (at_line != POS_TOP)
                    at_line = at_line + 1'b1;
                at_col = '0;
            end else if (at_col != POS_TOP) begin
                at_col = at_col + 1'b1;
            end
        end
        if (step_tokens.size() != 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
    endfunction

    // ---------------- source generation ----------------

    task automatic put_byte(input logic [ctl_pkg::CHAR_W-1:0] c);
        byte_queue.push_back('{ch: c, eoi: 1'b0});
        gen_count++;
    endtask

    task automatic put_end();
        byte_queue.push_back('{ch: ctl_pkg::CHAR_W'($urandom), eoi: 1'b1});
        gen_count++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [ctl_pkg::CHAR_W-1:0] rand_digit();
        return ctl_pkg::CHAR_W'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [ctl_pkg::CHAR_W-1:0] rand_alpha();
        return ctl_pkg::CHAR_W'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
    endfunction

    function automatic logic [ctl_pkg::CHAR_W-1:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha();
    endfunction

    function automatic logic [ctl_pkg::CHAR_W-1:0] rand_blank();
        return $urandom_range(0, 1) ? 8'h20 : ctl_pkg::CHAR_W'(8'h09 + $urandom_range(0, 4));
    endfunction

    function automatic logic [ctl_pkg::CHAR_W-1:0] rand_punct();
        case ($urandom_range(0, 9))
            0: return "*";
            1: return "+";
            2: return "-";
            3: return "=";
            4: return ";";
            5: return ",";
            6: return "(";
            7: return ")";
            8: return "{";
            default: return "}";
        endcase
    endfunction

    // any byte that cannot halt the lexer; no slash so no comment opens by accident
    function automatic logic [ctl_pkg::CHAR_W-1:0] rand_harmless();
        case ($urandom_range(0, 3))
            0: return rand_alpha();
            1: return rand_digit();
            2: return rand_punct();
            default: return rand_blank();
        endcase
    endfunction

    task automatic gen_token();
        int                         r;
        logic [ctl_pkg::CHAR_W-1:0] b;
        logic [ctl_pkg::CHAR_W-1:0] prev;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            put_text($urandom_range(0, 1) ? "int" : "return");
        end else if (r < 16) begin
            case ($urandom_range(0, 7))
                0: put_text("in");
                1: put_text("intx");
                2: put_text("i9");
                3: put_text("ret");
                4: put_text("retur");
                5: put_text("returns");
                6: put_text("Return");
                default: put_text("iNt");
            endcase
        end else if (r < 34) begin
            put_byte(rand_alpha());
            repeat ($urandom_range(0, 7)) put_byte(rand_alnum());
        end else if (r < 50) begin
            if ($urandom_range(0, 3) == 0) begin
                put_byte(ctl_pkg::CH_ZERO);
            end else begin
                put_byte(ctl_pkg::CHAR_W'("1" + $urandom_range(0, 8)));
                repeat ($urandom_range(0, 5)) put_byte(rand_digit());
            end
        end else if (r < 64) begin
            put_byte(rand_punct());
        end else if (r < 70) begin
            // lone slash, then a byte that cannot open a comment
            put_byte(ctl_pkg::CH_SLASH);
            do b = rand_harmless(); while (b == ctl_pkg::CH_STAR);
            put_byte(b);
        end else if (r < 76) begin
            put_byte(8'h20);
            put_byte(ctl_pkg::CH_SLASH);
            put_byte(ctl_pkg::CH_SLASH);
            repeat ($urandom_range(0, 10)) begin
                b = ctl_pkg::CHAR_W'($urandom_range(0, 255));
                if (b == ctl_pkg::CH_NEWLINE)
                    b = 8'h00;
                put_byte(b);
            end
            put_byte(ctl_pkg::CH_NEWLINE);
        end else if (r < 82) begin
            put_byte(8'h20);
            put_byte(ctl_pkg::CH_SLASH);
            put_byte(ctl_pkg::CH_STAR);
            prev = 8'h00;
            repeat ($urandom_range(0, 12)) begin
                b = ($urandom_range(0, 3) == 0) ? ctl_pkg::CH_STAR :
                    ctl_pkg::CHAR_W'($urandom_range(0, 255));
                if (prev == ctl_pkg::CH_STAR && b == ctl_pkg::CH_SLASH)
                    b = ctl_pkg::CH_STAR;
                put_byte(b);
                prev = b;
            end
            put_byte(ctl_pkg::CH_STAR);
            put_byte(ctl_pkg::CH_SLASH);
        end else if (r < 93) begin
            repeat ($urandom_range(1, 3)) put_byte(rand_harmless());
        end else if (r < 96) begin
            put_end();
        end else begin
            repeat ($urandom_range(1, 4)) put_byte(rand_blank());
        end
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 2)) put_byte(rand_blank());
    endtask

    task automatic gen_source(input int n);
        int target;
        target = gen_count + n;
        while (gen_count < target)
            gen_token();
    endtask

    // sender holds off until the queue is empty and every token is back
    task automatic wait_for_quiet();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || src_valid || tokens_due.size() != 0);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
            lexer_reset();
        end else begin
            if (src_valid && byte_ch.ready) begin
                lex_byte(src_char, src_eoi);
                if (src_eoi)
                    ends_in++;
                else
                    bytes_in++;
            end
            if (!src_valid || byte_ch.ready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    next_item = byte_queue.pop_front();
                    src_valid <= 1'b1;
                    src_char  <= next_item.ch;
                    src_eoi   <= next_item.eoi;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("tb: mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
        end else begin
            if (tok_ch.valid && snk_ready) begin
                got_tok = '{tok_ch.token_kind, tok_ch.symbol_code, tok_ch.token_line,
                            tok_ch.token_column, tok_ch.token_length, tok_ch.last_of_run};
                if (tokens_due.size() == 0) begin
                    report_mismatch($sformatf("token kind %0d line %0d col %0d, none expected",
                                              got_tok.kind, got_tok.line, got_tok.col));
                end else begin
                    want_tok = tokens_due.pop_front();
                    if (got_tok.kind !== want_tok.kind || got_tok.sym !== want_tok.sym ||
                        got_tok.line !== want_tok.line || got_tok.col !== want_tok.col ||
                        got_tok.len !== want_tok.len || got_tok.last !== want_tok.last)
                        report_mismatch($sformatf(
                            "token %0d: got k%0d s%02h l%0d c%0d n%0d e%0b want k%0d s%02h l%0d c%0d n%0d e%0b",
                            tokens_seen, got_tok.kind, got_tok.sym, got_tok.line, got_tok.col,
                            got_tok.len, got_tok.last, want_tok.kind, want_tok.sym,
                            want_tok.line, want_tok.col, want_tok.len, want_tok.last));
                end
                tokens_seen++;
            end
            snk_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (src_valid && byte_ch.ready) || (tok_ch.valid && snk_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        do @(posedge i_clk);
        while (idle_cycles < STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ---------------- stimulus ----------------

    initial begin
        src_idle_pct = 14;
        snk_idle_pct = 72;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keywords, two tokens from one byte, leading zero, lone slash, comments
        put_text("int\treturn");
        put_byte(8'h0D);
        put_text("x9=01/(/*a**/");
        put_byte(8'h0C);
        put_text("Zq");
        put_end();
        put_text("/*");
        put_end();
        gen_source(PHASE_BYTES);
        wait_for_quiet();

        src_idle_pct = 72;
        snk_idle_pct = 14;
        gen_source(PHASE_BYTES);
        wait_for_quiet();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        gen_source(PHASE_BYTES);
        // length saturation on an identifier and a number
        put_text(" q");
        repeat (299) put_byte(rand_alnum());
        put_text(";7");
        repeat (259) put_byte(rand_digit());
        put_byte(ctl_pkg::CH_NEWLINE);
        put_text("x+");
        put_byte(ctl_pkg::CH_NEWLINE);
        put_text("y ");
        put_end();
        wait_for_quiet();

        // an illegal byte halts the lexer; what follows yields nothing
        case ($urandom_range(0, 2))
            0: put_byte(8'h00);
            1: put_byte(ctl_pkg::CHAR_W'(8'h80 + $urandom_range(0, 127)));
            default: put_byte("#");
        endcase
        put_byte(8'hFF);
        put_byte(8'h00);
        put_text("a");
        put_end();
        wait_for_quiet();
        repeat (16) @(posedge i_clk);

        $display("tb: %0d bytes and %0d end marks sent, %0d tokens checked",
                 bytes_in, ends_in, tokens_seen);
        $display("tb: covered keywords, comments, length saturation, halt on a bad byte");
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ctl_pkg.sv
rtl/ctl_if.sv
rtl/ctl_lex_core.sv
rtl/ctl_tok_fifo.sv
rtl/c_subset_token_lexer.sv
dv/testbench.sv
